// ----- hw/rtl/cursor_bracket_match_highlighter_unit_defines.svh -----
// Assertion macros shared by the bracket highlighter RTL.
`ifndef CURSOR_BRACKET_MATCH_HIGHLIGHTER_UNIT_DEFINES_SVH
`define CURSOR_BRACKET_MATCH_HIGHLIGHTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CBMH_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("bracket highlighter: invariant violated");
`define CBMH_ASSERT_IMPLIES(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("bracket highlighter: implication violated");
`define CBMH_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("bracket highlighter: next-cycle check violated");
`else
`define CBMH_ASSERT_ALWAYS(lbl, expr)
`define CBMH_ASSERT_IMPLIES(lbl, cond, expr)
`define CBMH_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// ----- hw/rtl/cbmh_pkg.sv -----
// Types, constants and character helpers for the bracket highlighter.
package cbmh_pkg;

  localparam int MAX_LINE = 64;
  localparam int AW       = $clog2(MAX_LINE);
  localparam int LW       = $clog2(MAX_LINE + 1);
  localparam int CUR_W    = 7;
  localparam int NEST_W   = 7;
  localparam int PW       = (LW > CUR_W) ? LW : CUR_W;

  typedef logic [PW-1:0] pos_t;

  typedef enum logic [1:0] {
    NO_DIR,
    DIR_FWD,
    DIR_BACK
  } dir_t;

  localparam logic [1:0] CLS_PLAIN   = 2'd0;
  localparam logic [1:0] CLS_MATCH   = 2'd1;
  localparam logic [1:0] CLS_SPECIAL = 2'd2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h27;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] colour_class;
    logic       last_out;
  } beat_t;

  function automatic dir_t paren_dir(input logic [7:0] ch);
    dir_t d;
    if (ch == CH_LPAREN || ch == CH_LBRACK) begin
      d = DIR_FWD;
    end else if (ch == CH_RPAREN || ch == CH_RBRACK) begin
      d = DIR_BACK;
    end else begin
      d = NO_DIR;
    end
    return d;
  endfunction

  function automatic logic is_special(input logic [7:0] ch);
    return ch inside {CH_AT, CH_DOLLAR, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK};
  endfunction

endpackage

// ----- hw/rtl/cbmh_in_if.sv -----
// Input channel: one line byte per beat with cursor and last mark.
interface cbmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic [6:0] cursor_col;
  logic       line_end;

  modport source (output valid, char_in, cursor_col, line_end, input ready);
  modport sink   (input valid, char_in, cursor_col, line_end, output ready);
endinterface

// ----- hw/rtl/cbmh_out_if.sv -----
// Output channel: one classified line byte per beat.
interface cbmh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] colour_class;
  logic       last_out;

  modport source (output valid, char_out, colour_class, last_out, input ready);
  modport sink   (input valid, char_out, colour_class, last_out, output ready);
endinterface

// ----- hw/rtl/cbmh_emit_stage.sv -----
// Output register stage holding one classified beat towards the sink.
module cbmh_emit_stage
  import cbmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  beat_t             beat,
  output logic              room,
  cbmh_out_if.source        tx
);

  logic  valid;
  beat_t held;

  assign room = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= beat;
    end
  end

  assign tx.valid        = valid;
  assign tx.char_out     = held.char_out;
  assign tx.colour_class = held.colour_class;
  assign tx.last_out     = held.last_out;

endmodule

// ----- hw/rtl/cursor_bracket_match_highlighter_unit.sv -----
// Top level of the matching-bracket highlighter: line store, search and emit control.
//
//  channel | dir | beat contents                         | accepted when
//  rx      | in  | char_in, cursor_col, line_end         | rx.valid & rx.ready
//  tx      | out | char_out, colour_class, last_out      | tx.valid & tx.ready
//
// Load: one byte per cycle while rx.valid is high; rx.ready is high only while loading.
// After the last byte, S_SEL_AT, S_SEL_BEFORE and, if needed, S_SEL_CHK pick the bracket;
// S_SCAN_RD and S_SCAN_CHK scan each byte; S_EMIT_RD starts the emit pass and
// S_EMIT_WR sends one byte per cycle while room is high; all use one read port.
// Reset is synchronous; the line store needs no clearing pass.
// tx stalls hold the emit pass; the next line loads while the final beat waits.
`include "cursor_bracket_match_highlighter_unit_defines.svh"

module cursor_bracket_match_highlighter_unit
  import cbmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cbmh_in_if.sink    rx,
  cbmh_out_if.source tx
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SEL_AT,
    S_SEL_BEFORE,
    S_SEL_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t            state;
  logic [LW-1:0]     fill_count;
  logic [NEST_W-1:0] nest_depth;
  pos_t              len;
  pos_t              cur;
  pos_t              sel;
  pos_t              match;
  pos_t              pos;
  logic              have_sel;
  logic              have_match;
  dir_t              dir;

  logic [7:0]        mem [MAX_LINE];
  logic [7:0]        rd_data;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  pos_t              rd_pos;
  logic              push;
  logic              room;
  beat_t             beat;

  pos_t              cur_m1;
  pos_t              pos_p1;
  pos_t              pos_m1;
  pos_t              len_next;
  dir_t              rd_dir;
  dir_t              opp_dir;
  logic              cur_in;
  logic              prev_in;
  logic              last_beat;

  assign rx.ready  = (state == S_LOAD);
  assign accept    = rx.valid && rx.ready;
  assign wr_en     = accept && (fill_count < LW'(MAX_LINE));
  assign len_next  = pos_t'(fill_count) + pos_t'(wr_en);

  assign cur_m1    = cur - pos_t'(1);
  assign pos_p1    = pos + pos_t'(1);
  assign pos_m1    = pos - pos_t'(1);
  assign cur_in    = cur < len;
  assign prev_in   = (cur != '0) && (cur_m1 < len);
  assign rd_dir    = paren_dir(rd_data);
  assign opp_dir   = (dir == DIR_FWD) ? DIR_BACK : DIR_FWD;
  assign last_beat = (pos_p1 == len);

  always_comb begin
    rd_en  = 1'b0;
    rd_pos = pos;
    push   = 1'b0;
    case (state)
      S_SEL_AT: begin
        rd_en  = cur_in;
        rd_pos = cur;
      end
      S_SEL_BEFORE: begin
        rd_en  = !(cur_in && rd_dir != NO_DIR) && prev_in;
        rd_pos = cur_m1;
      end
      S_SCAN_RD: begin
        rd_en  = pos < len;
        rd_pos = pos;
      end
      S_EMIT_RD: begin
        rd_en  = 1'b1;
        rd_pos = pos;
      end
      S_EMIT_WR: begin
        push   = room;
        rd_en  = room && !last_beat;
        rd_pos = pos_p1;
      end
      default: begin
        rd_en  = 1'b0;
        rd_pos = pos;
      end
    endcase
  end

  always_comb begin
    beat.char_out = rd_data;
    beat.last_out = last_beat;
    if ((have_sel && pos == sel) || (have_match && pos == match)) begin
      beat.colour_class = CLS_MATCH;
    end else if (is_special(rd_data)) begin
      beat.colour_class = CLS_SPECIAL;
    end else begin
      beat.colour_class = CLS_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_count[AW-1:0]] <= rx.char_in;
    end
    if (rd_en) begin
      rd_data <= mem[rd_pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill_count <= '0;
      nest_depth <= '0;
      have_sel   <= 1'b0;
      have_match <= 1'b0;
      dir        <= NO_DIR;
      len        <= '0;
      cur        <= '0;
      sel        <= '0;
      match      <= '0;
      pos        <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (wr_en) begin
              fill_count <= fill_count + LW'(1);
            end
            if (rx.line_end) begin
              len        <= len_next;
              cur        <= pos_t'(rx.cursor_col);
              have_sel   <= 1'b0;
              have_match <= 1'b0;
              state      <= S_SEL_AT;
            end
          end
        end
        S_SEL_AT: begin
          state <= S_SEL_BEFORE;
        end
        S_SEL_BEFORE: begin
          if (cur_in && rd_dir != NO_DIR) begin
            have_sel   <= 1'b1;
            sel        <= cur;
            dir        <= rd_dir;
            nest_depth <= '0;
            pos        <= (rd_dir == DIR_BACK) ? cur_m1 : cur + pos_t'(1);
            state      <= S_SCAN_RD;
          end else if (prev_in) begin
            state <= S_SEL_CHK;
          end else begin
            pos   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_SEL_CHK: begin
          if (rd_dir != NO_DIR) begin
            have_sel   <= 1'b1;
            sel        <= cur_m1;
            dir        <= rd_dir;
            nest_depth <= '0;
            pos        <= (rd_dir == DIR_BACK) ? cur_m1 - pos_t'(1) : cur;
            state      <= S_SCAN_RD;
          end else begin
            pos   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_SCAN_RD: begin
          if (pos < len) begin
            state <= S_SCAN_CHK;
          end else begin
            pos   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_SCAN_CHK: begin
          if (rd_dir == opp_dir && nest_depth == '0) begin
            have_match <= 1'b1;
            match      <= pos;
            pos        <= '0;
            state      <= S_EMIT_RD;
          end else begin
            if (rd_dir == dir) begin
              nest_depth <= nest_depth + NEST_W'(1);
            end else if (rd_dir == opp_dir) begin
              nest_depth <= nest_depth - NEST_W'(1);
            end
            pos   <= (dir == DIR_FWD) ? pos_p1 : pos_m1;
            state <= S_SCAN_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (push) begin
            if (last_beat) begin
              fill_count <= '0;
              state      <= S_LOAD;
            end else begin
              pos <= pos_p1;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  cbmh_emit_stage u_emit (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .beat (beat),
    .room (room),
    .tx   (tx)
  );

  `CBMH_ASSERT_ALWAYS(a_fill_bound, fill_count <= LW'(MAX_LINE))
  `CBMH_ASSERT_IMPLIES(a_match_needs_sel, have_match, have_sel)
  `CBMH_ASSERT_IMPLIES(a_read_in_line, rd_en, rd_pos < len)
  `CBMH_ASSERT_IMPLIES(a_push_has_room, push, room)
  `CBMH_ASSERT_NEXT(a_line_done, push && last_beat, state == S_LOAD && fill_count == '0)

endmodule
